// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the codec core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVP_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SVP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: hw/rtl/svp_pkg.sv
`timescale 1ns / 1ps

package svp_pkg;

    localparam int unsigned GROUP_LEN = 7;

    localparam logic [7:0] TOP_BIT    = 8'h80;
    localparam logic [7:0] LOW_BITS   = 8'h7F;
    localparam logic [2:0] GROUP_LAST = 3'd6;

    localparam logic DIR_PACK   = 1'b0;
    localparam logic DIR_UNPACK = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic       en;
        logic [2:0] addr;
        logic [7:0] data;
    } buf_wr_t;

endpackage

// File: hw/rtl/svp_ifs.sv
`timescale 1ns / 1ps

interface svp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface svp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic [7:0] checksum;

    modport source (output valid, output out_byte, output byte_valid,
                    output last_of_run, output checksum, input ready);
    modport sink (input valid, input out_byte, input byte_valid,
                  input last_of_run, input checksum, output ready);
endinterface

interface svp_cfg_if;
    logic valid;
    logic ready;
    logic direction;

    modport source (output valid, output direction, input ready);
    modport sink (input valid, input direction, output ready);
endinterface

// File: hw/rtl/seven_bit_pack_codec_xor_checksum_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Seven-bit sysex packing codec with running XOR checksum. The direction
// register picks packing (0) or unpacking (1); writing it also restarts the
// message state. Unpacking takes one item per cycle while the output side is
// free and no register write is offered, and gives at most one result, held
// in the output register. Packing takes one byte per cycle on the same terms
// while a group fills; the byte that closes a group (seventh byte or end of
// message) starts an emit pass of n+1 results for n bytes in the group, one
// result per cycle while the output side takes them, during which no item is
// accepted. The emit pass walks the seven-entry group buffer, one slot a
// cycle as results go out, via a single XOR checksum unit shared by both directions.
module seven_bit_pack_codec_xor_checksum_core
    import svp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    svp_cfg_if.sink   cfg,
    svp_in_if.sink    data,
    svp_out_if.source result
);

    state_t     state_reg, state_next;
    logic       dir_reg, dir_next;
    logic [2:0] pos_reg, pos_next;
    logic [7:0] hdr_reg, hdr_next;
    logic [7:0] chk_reg, chk_next;
    logic [2:0] emit_idx_reg, emit_idx_next;
    logic [2:0] emit_n_reg, emit_n_next;
    logic       eom_reg, eom_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_bv_reg, out_bv_next;
    logic       out_last_reg, out_last_next;
    logic [7:0] out_chk_reg, out_chk_next;

    logic       out_free;
    logic       in_acc;
    logic       cfg_acc;
    logic       emit_last;
    logic [7:0] rd_data;
    logic [2:0] rd_addr;
    logic [7:0] emit_byte;
    logic [7:0] upk_byte;
    logic [7:0] xor_src;
    logic [7:0] chk_xor;
    buf_wr_t    buf_wr;

    svp_group_buf u_group_buf (
        .clk     (clk),
        .wr      (buf_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free   = !out_valid_reg || result.ready;
    // Hold input while a register write is offered; take writes only when drained.
    assign data.ready = (state_reg == S_IDLE) && out_free && !cfg.valid;
    assign cfg.ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_acc     = data.valid && data.ready;
    assign cfg_acc    = cfg.valid && cfg.ready;

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.byte_valid  = out_bv_reg;
    assign result.last_of_run = out_last_reg;
    assign result.checksum    = out_chk_reg;

    // Slot 0 of the emit pass is the header; slot k reads group byte k-1.
    // Address the upcoming slot so its byte is registered when it is emitted.
    assign rd_addr   = emit_idx_next - 3'd1;
    assign emit_byte = (emit_idx_reg == 3'd0) ? hdr_reg : (rd_data & LOW_BITS);
    assign emit_last = (emit_idx_reg == emit_n_reg);

    // Restore the top bit from the held header; a set top bit in the input stays.
    assign upk_byte = (8'(hdr_reg << pos_reg) & TOP_BIT) | data.data_byte;

    // Shared checksum unit.
    assign xor_src = (state_reg == S_EMIT) ? emit_byte : data.data_byte;
    assign chk_xor = chk_reg ^ xor_src;

    assign buf_wr.en   = in_acc && (dir_reg == DIR_PACK);
    assign buf_wr.addr = pos_reg;
    assign buf_wr.data = data.data_byte;

    always_comb
    begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        pos_next       = pos_reg;
        hdr_next       = hdr_reg;
        chk_next       = chk_reg;
        emit_idx_next  = emit_idx_reg;
        emit_n_next    = emit_n_reg;
        eom_next       = eom_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_bv_next    = out_bv_reg;
        out_last_next  = out_last_reg;
        out_chk_next   = out_chk_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        priority if (cfg_acc)
        begin
            dir_next = cfg.direction;
            pos_next = '0;
            hdr_next = '0;
            chk_next = '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (dir_reg == DIR_UNPACK)
                        begin
                            chk_next = chk_xor;
                            if (pos_reg == 3'd0)
                            begin
                                hdr_next = data.data_byte;
                                pos_next = 3'd1;
                                if (data.end_of_message)
                                begin
                                    // Message ends on a header: checksum-only item.
                                    out_valid_next = 1'b1;
                                    out_byte_next  = '0;
                                    out_bv_next    = 1'b0;
                                    out_last_next  = 1'b1;
                                    out_chk_next   = chk_xor;
                                end
                            end
                            else
                            begin
                                pos_next       = pos_reg + 3'd1;
                                out_valid_next = 1'b1;
                                out_byte_next  = upk_byte;
                                out_bv_next    = 1'b1;
                                out_last_next  = data.end_of_message;
                                out_chk_next   = data.end_of_message ? chk_xor : 8'h00;
                            end
                            if (data.end_of_message)
                            begin
                                pos_next = '0;
                                chk_next = '0;
                            end
                        end
                        else
                        begin
                            // Byte j lands in header bit 6-j.
                            hdr_next = hdr_reg |
                                ((data.data_byte & TOP_BIT) >> ({1'b0, pos_reg} + 4'd1));
                            if ((pos_reg == GROUP_LAST) || data.end_of_message)
                            begin
                                state_next    = S_EMIT;
                                emit_idx_next = '0;
                                emit_n_next   = pos_reg + 3'd1;
                                eom_next      = data.end_of_message;
                                pos_next      = '0;
                            end
                            else
                            begin
                                pos_next = pos_reg + 3'd1;
                            end
                        end
                    end
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        chk_next       = chk_xor;
                        out_valid_next = 1'b1;
                        out_byte_next  = emit_byte;
                        out_bv_next    = 1'b1;
                        out_last_next  = eom_reg && emit_last;
                        out_chk_next   = (eom_reg && emit_last) ? chk_xor : 8'h00;
                        if (emit_last)
                        begin
                            state_next = S_IDLE;
                            hdr_next   = '0;
                            if (eom_reg)
                            begin
                                chk_next = '0;
                            end
                        end
                        else
                        begin
                            emit_idx_next = emit_idx_reg + 3'd1;
                        end
                    end
                end

                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dir_reg       <= DIR_PACK;
            pos_reg       <= '0;
            hdr_reg       <= '0;
            chk_reg       <= '0;
            emit_idx_reg  <= '0;
            emit_n_reg    <= '0;
            eom_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            pos_reg       <= pos_next;
            hdr_reg       <= hdr_next;
            chk_reg       <= chk_next;
            emit_idx_reg  <= emit_idx_next;
            emit_n_reg    <= emit_n_next;
            eom_reg       <= eom_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_bv_reg   <= out_bv_next;
        out_last_reg <= out_last_next;
        out_chk_reg  <= out_chk_next;
    end

    `SVP_ASSERT_SAME(a_chk_zero_unless_last, clk, rst_n, result.valid && !result.last_of_run, result.checksum == 8'h00)
    `SVP_ASSERT_SAME(a_emit_idx_bound, clk, rst_n, state_reg == S_EMIT, emit_idx_reg <= emit_n_reg)
    `SVP_ASSERT_SAME(a_pack_pos_bound, clk, rst_n, dir_reg == DIR_PACK, pos_reg != 3'd7)
    `SVP_ASSERT_NEXT(a_close_starts_emit, clk, rst_n, in_acc && !cfg_acc && (dir_reg == DIR_PACK) && (data.end_of_message || (pos_reg == GROUP_LAST)), state_reg == S_EMIT)

endmodule

// File: hw/rtl/svp_group_buf.sv
`timescale 1ns / 1ps

module svp_group_buf
    import svp_pkg::*;
(
    input  logic       clk,
    input  buf_wr_t    wr,
    input  logic [2:0] rd_addr,
    output logic [7:0] rd_data
);

    logic [7:0] byte_reg [GROUP_LEN];

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr <= GROUP_LAST))
        begin
            byte_reg[wr.addr] <= wr.data;
        end
    end

    // Only slots of the current group are ever read back.
    always_ff @(posedge clk)
    begin
        if (rd_addr <= GROUP_LAST)
        begin
            rd_data <= byte_reg[rd_addr];
        end
        else
        begin
            rd_data <= '0;
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import svp_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic [7:0] checksum;
    } codec_res_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic       dir;
        logic [7:0] data_byte;
        logic       eom;
        logic [1:0] n_typed;
        codec_res_t first_res;
        codec_res_t second_res;
    } row_t;

    localparam int N_ROWS           = 24;
    localparam int RANDOM_PER_PHASE = 128;
    localparam int SETTLE_CYCLES    = 12;
    localparam int STALL_LIMIT      = 5000;
    localparam codec_res_t NO_RES   = '0;

    logic clk = 1'b0;
    logic rst_n;

    svp_cfg_if cfg_ch();
    svp_in_if  in_ch();
    svp_out_if out_ch();

    seven_bit_pack_codec_xor_checksum_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .data   (in_ch),
        .result (out_ch)
    );

    always #10 clk = ~clk;

    // Predictor state
    logic       pred_dir;
    logic [7:0] group_buf [GROUP_LEN];
    int         fill_count;
    logic [7:0] header_byte;
    logic [7:0] xor_sum;

    codec_res_t pending_results [$];
    codec_res_t fresh_results [$];
    codec_res_t oldest;
    row_t       directed_rows [N_ROWS];

    int snd_idle_pct   = 0;
    int rcv_idle_pct   = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;
    int n_items        = 0;
    int n_unpack_items = 0;
    int n_results      = 0;
    int n_sum_only     = 0;
    int n_cfg_writes   = 0;

    function automatic codec_res_t mk_res(input logic [7:0] b, input logic v, input logic l,
                                          input logic [7:0] c);
        codec_res_t r;
        r.out_byte    = b;
        r.byte_valid  = v;
        r.last_of_run = l;
        r.checksum    = c;
        return r;
    endfunction

    function automatic row_t mk_row(input row_kind_t k, input logic d, input logic [7:0] b,
                                    input logic e, input logic [1:0] n,
                                    input codec_res_t r0, input codec_res_t r1);
        row_t r;
        r.kind       = k;
        r.dir        = d;
        r.data_byte  = b;
        r.eom        = e;
        r.n_typed    = n;
        r.first_res  = r0;
        r.second_res = r1;
        return r;
    endfunction

    task automatic apply_direction(input logic d);
        pred_dir    = d;
        fill_count  = 0;
        header_byte = '0;
        xor_sum     = '0;
    endtask

    task automatic codec_step(input logic [7:0] b, input logic e);
        logic [7:0] hdr;
        logic [7:0] d;
        logic [7:0] shifted;
        logic       last;
        int         n;
        int         pos;
        int         j;
        fresh_results.delete();
        if (pred_dir == DIR_UNPACK)
        begin
            pos = fill_count & 7;
            xor_sum ^= b;
            if (pos == 0)
            begin
                header_byte = b;
                fill_count  = 1;
                if (e)
                    fresh_results = {fresh_results, mk_res(8'h00, 1'b0, 1'b1, xor_sum)};
            end
            else
            begin
                // restore the top bit from the held header, keep any set top bit
                shifted = header_byte << pos;
                d = (shifted & TOP_BIT) | b;
                fresh_results = {fresh_results, mk_res(d, 1'b1, e, e ? xor_sum : 8'h00)};
                fill_count = (pos + 1) & 7;
            end
            if (e)
            begin
                fill_count = 0;
                xor_sum    = '0;
            end
        end
        else
        begin
            if (fill_count >= GROUP_LEN)
                fill_count = 0;
            group_buf[fill_count] = b;
            fill_count++;
            if (fill_count == GROUP_LEN || e)
            begin
                n   = fill_count;
                hdr = '0;
                for (j = 0; j < n; j++)
                    hdr |= (group_buf[j] & TOP_BIT) >> (j + 1);
                xor_sum ^= hdr;
                fresh_results = {fresh_results, mk_res(hdr, 1'b1, 1'b0, 8'h00)};
                for (j = 0; j < n; j++)
                begin
                    d = group_buf[j] & LOW_BITS;
                    xor_sum ^= d;
                    last = e && (j + 1 == n);
                    fresh_results = {fresh_results,
                                     mk_res(d, 1'b1, last, last ? xor_sum : 8'h00)};
                end
                fill_count = 0;
                if (e)
                    xor_sum = '0;
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e, input logic [1:0] n_typed,
                             input codec_res_t r0, input codec_res_t r1);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.end_of_message <= e;
        do @(posedge clk); while (!in_ch.ready);
        n_items++;
        if (pred_dir == DIR_UNPACK)
            n_unpack_items++;
        codec_step(b, e);
        if (fresh_results.size() == 1 && !fresh_results[0].byte_valid)
            n_sum_only++;
        if (n_typed == 0)
        begin
            pending_results = {pending_results, fresh_results};
        end
        else
        begin
            pending_results = {pending_results, r0};
            if (n_typed > 1)
                pending_results = {pending_results, r1};
        end
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_direction(input logic d);
        hold_until_drained();
        // let a group with no result pending settle
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.direction <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        apply_direction(d);
        n_cfg_writes++;
    endtask

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                flag_mismatch("unexpected result out_byte", 8'h00, out_ch.out_byte);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (out_ch.out_byte !== oldest.out_byte)
                    flag_mismatch("out_byte", oldest.out_byte, out_ch.out_byte);
                if (out_ch.byte_valid !== oldest.byte_valid)
                    flag_mismatch("byte_valid", oldest.byte_valid, out_ch.byte_valid);
                if (out_ch.last_of_run !== oldest.last_of_run)
                    flag_mismatch("last_of_run", oldest.last_of_run, out_ch.last_of_run);
                if (out_ch.checksum !== oldest.checksum)
                    flag_mismatch("checksum", oldest.checksum, out_ch.checksum);
            end
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("FAIL seven_bit_pack_codec_xor_checksum_core");
        $finish;
    end

    initial
    begin
        int         phase;
        int         phase_items;
        int         msg_len;
        int         i;
        logic       noisy;
        logic       broken;
        logic [7:0] b;
        row_t       row;

        rst_n                <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.direction     <= DIR_PACK;
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= '0;
        in_ch.end_of_message <= 1'b0;
        apply_direction(DIR_PACK);

        directed_rows = '{
            mk_row(ROW_CFG,  DIR_PACK,   8'h00, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'hFF, 1, 2, mk_res(8'h40, 1, 0, 8'h00),
                   mk_res(8'h7F, 1, 1, 8'h3F)),
            mk_row(ROW_ITEM, DIR_PACK,   8'h00, 1, 2, mk_res(8'h00, 1, 0, 8'h00),
                   mk_res(8'h00, 1, 1, 8'h00)),
            // full group of seven, no end of message
            mk_row(ROW_ITEM, DIR_PACK,   8'h80, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h01, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'hFF, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h7F, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h80, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h00, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'hC3, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h55, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'hAA, 1, 0, NO_RES, NO_RES),
            // leave a group open, then switch direction
            mk_row(ROW_ITEM, DIR_PACK,   8'h9C, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_CFG,  DIR_UNPACK, 8'h00, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'hAA, 1, 1, mk_res(8'h00, 0, 1, 8'hAA), NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h7F, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h00, 1, 1, mk_res(8'h80, 1, 1, 8'h7F), NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h00, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'hFF, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h80, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h01, 1, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h55, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_CFG,  DIR_PACK,   8'h00, 0, 0, NO_RES, NO_RES),
            mk_row(ROW_ITEM, DIR_PACK,   8'h01, 1, 2, mk_res(8'h00, 1, 0, 8'h00),
                   mk_res(8'h01, 1, 1, 8'h01))
        };

        snd_idle_pct = 22;
        rcv_idle_pct = 51;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_ROWS; i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_direction(row.dir);
            else
                send_byte(row.data_byte, row.eom, row.n_typed, row.first_res, row.second_res);
        end

        for (phase = 0; phase < 3; phase++)
        begin
            snd_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 51 : 0;
            rcv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 22 : 0;
            phase_items  = 0;
            while (phase_items < RANDOM_PER_PHASE)
            begin
                if ($urandom_range(3) == 0)
                    write_direction(1'($urandom_range(1)));
                msg_len = ($urandom_range(7) == 0) ? $urandom_range(40, 17)
                                                   : $urandom_range(16, 1);
                noisy   = (pred_dir == DIR_UNPACK) && ($urandom_range(4) == 0);
                broken  = ($urandom_range(11) == 0);
                for (i = 0; i < msg_len; i++)
                begin
                    // unpack traffic is mostly seven-bit clean
                    if (pred_dir == DIR_PACK || noisy)
                    begin
                        b = 8'($urandom_range(255));
                    end
                    else
                    begin
                        b = 8'($urandom_range(127));
                        if ($urandom_range(7) == 0)
                            b[7] = 1'b1;
                    end
                    if ($urandom_range(19) == 0)
                        hold_until_drained();
                    send_byte(b, (i == msg_len - 1) && !broken, 2'd0, NO_RES, NO_RES);
                end
                phase_items += msg_len;
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            flag_mismatch("results still pending", 8'h00, 8'(pending_results.size()));

        $display("Covered %0d items (%0d unpacked), %0d results (%0d checksum-only)",
                 n_items, n_unpack_items, n_results, n_sum_only);
        $display("%0d direction writes, stall mixes 22/51, 51/22 and none; %0d mismatches",
                 n_cfg_writes, mismatches);
        if (mismatches == 0)
            $display("PASS seven_bit_pack_codec_xor_checksum_core");
        else
            $display("FAIL seven_bit_pack_codec_xor_checksum_core");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/svp_pkg.sv
hw/rtl/svp_ifs.sv
hw/rtl/svp_group_buf.sv
hw/rtl/seven_bit_pack_codec_xor_checksum_core.sv
sim/tb.sv
